@@ rtl/gbts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// shared types, codes and defaults of the gap buffer text store
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int CAPACITY_DEF = 4096;
    localparam int ACT_W        = 2;
    localparam int POS_W        = 13;
    localparam int CHAR_W       = 16;
    localparam int STAT_W       = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EXEC,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

@@ rtl/gbts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gbts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/gbts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ctrl
// action sequencer: checks, gap walk over the ram, edit and result register
// ----------------------------------------------------------------------------
module gbts_ctrl #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gbts_pkg::ACT_W-1:0]    action,
    input  wire logic [gbts_pkg::POS_W-1:0]    position,
    input  wire logic [gbts_pkg::CHAR_W-1:0]   character,
    input  wire logic [gbts_pkg::POS_W-1:0]    count,
    output logic                               busy,
    output logic                               done,
    output logic      [gbts_pkg::CHAR_W-1:0]   read_char,
    output logic      [gbts_pkg::POS_W-1:0]    text_length,
    output logic      [gbts_pkg::STAT_W-1:0]   status,
    output logic                               mem_we,
    output logic      [$clog2(CAPACITY)-1:0]   mem_waddr,
    output logic      [gbts_pkg::CHAR_W-1:0]   mem_wdata,
    output logic      [$clog2(CAPACITY)-1:0]   mem_raddr,
    input  wire logic [gbts_pkg::CHAR_W-1:0]   mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > gbts_pkg::POS_W) ? LW : gbts_pkg::POS_W) + 1;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    gbts_pkg::state_t state_reg, state_next;

    logic [gbts_pkg::ACT_W-1:0]  act_reg,  act_next;
    logic [gbts_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [LW-1:0]               cnt_reg,  cnt_next;
    logic [LW-1:0]               tgt_reg,  tgt_next;
    logic [LW-1:0]               gs_reg,   gs_next;
    logic [LW-1:0]               gl_reg,   gl_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               wa_reg,   wa_next;
    logic                        done_reg, done_next;
    logic [gbts_pkg::CHAR_W-1:0] rc_reg,   rc_next;
    logic [gbts_pkg::POS_W-1:0]  tl_reg,   tl_next;
    logic [gbts_pkg::STAT_W-1:0] st_reg,   st_next;

    logic          accept;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] cnt_x;
    logic [CW-1:0] end_x;
    logic [CW-1:0] len_x;
    logic          ins_ok;
    logic          rem_ok;
    logic          rd_ok;
    logic          ins_full;
    logic [AW-1:0] rd_addr;
    logic          walk_done;

    // admission checks on the incoming transfer
    always_comb
    begin
        accept    = start && (state_reg == gbts_pkg::ST_IDLE);
        pos_x     = CW'(position);
        cnt_x     = CW'(count);
        end_x     = pos_x + cnt_x;
        len_x     = CW'(CAP_L - gl_reg);
        ins_full  = (gl_reg == '0);
        ins_ok    = (pos_x <= len_x) && !ins_full;
        rem_ok    = (end_x <= len_x);
        rd_ok     = (pos_x < len_x);
        // logical to physical: skip the gap when past its start
        rd_addr   = (pos_x < CW'(gs_reg)) ? AW'(pos_x) : AW'(pos_x + CW'(gl_reg));
        walk_done = (gs_reg == tgt_reg) && !pend_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        gbts_pkg::ACT_INSERT:
                        begin
                            if (pos_x <= len_x && !ins_full)
                            begin
                                state_next = gbts_pkg::ST_WALK;
                            end
                        end
                        gbts_pkg::ACT_REMOVE:
                        begin
                            if (rem_ok)
                            begin
                                state_next = gbts_pkg::ST_WALK;
                            end
                        end
                        gbts_pkg::ACT_READ:
                        begin
                            if (rd_ok)
                            begin
                                state_next = gbts_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = gbts_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            gbts_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = gbts_pkg::ST_EXEC;
                end
            end
            gbts_pkg::ST_EXEC:
            begin
                state_next = gbts_pkg::ST_IDLE;
            end
            gbts_pkg::ST_READ:
            begin
                state_next = gbts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gbts_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, ram requests and result register
    always_comb
    begin
        logic [LW-1:0] new_gl;
        logic [CW-1:0] new_len;

        act_next  = act_reg;
        char_next = char_reg;
        cnt_next  = cnt_reg;
        tgt_next  = tgt_reg;
        gs_next   = gs_reg;
        gl_next   = gl_reg;
        pend_next = pend_reg;
        wa_next   = wa_reg;
        done_next = 1'b0;
        rc_next   = rc_reg;
        tl_next   = tl_reg;
        st_next   = st_reg;
        mem_we    = 1'b0;
        mem_waddr = wa_reg;
        mem_wdata = mem_rdata;
        mem_raddr = rd_addr;
        new_gl    = gl_reg;
        new_len   = len_x;

        unique case (state_reg)
            gbts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    act_next  = action;
                    char_next = character;
                    cnt_next  = LW'(cnt_x);
                    tgt_next  = (action == gbts_pkg::ACT_INSERT) ? LW'(pos_x) : LW'(end_x);
                    pend_next = 1'b0;
                    // refused actions answer at once
                    if (!((action == gbts_pkg::ACT_INSERT && ins_ok)
                          || (action == gbts_pkg::ACT_REMOVE && rem_ok)
                          || (action == gbts_pkg::ACT_READ && rd_ok)))
                    begin
                        done_next = 1'b1;
                        rc_next   = '0;
                        tl_next   = len_x[gbts_pkg::POS_W-1:0];
                        if (action == gbts_pkg::ACT_INSERT && pos_x <= len_x)
                        begin
                            st_next = gbts_pkg::STAT_FULL;
                        end
                        else
                        begin
                            st_next = gbts_pkg::STAT_RANGE;
                        end
                    end
                end
            end
            gbts_pkg::ST_WALK:
            begin
                // write back the element fetched last cycle
                mem_we = pend_reg;
                if (gs_reg != tgt_reg)
                begin
                    pend_next = 1'b1;
                    if (gs_reg < tgt_reg)
                    begin
                        mem_raddr = AW'(gs_reg + gl_reg);
                        wa_next   = AW'(gs_reg);
                        gs_next   = gs_reg + LW'(1);
                    end
                    else
                    begin
                        mem_raddr = AW'(gs_reg - LW'(1));
                        wa_next   = AW'(gs_reg + gl_reg - LW'(1));
                        gs_next   = gs_reg - LW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            gbts_pkg::ST_EXEC:
            begin
                if (act_reg == gbts_pkg::ACT_INSERT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(gs_reg);
                    mem_wdata = char_reg;
                    gs_next   = gs_reg + LW'(1);
                    new_gl    = gl_reg - LW'(1);
                end
                else
                begin
                    gs_next = gs_reg - cnt_reg;
                    new_gl  = gl_reg + cnt_reg;
                end
                gl_next   = new_gl;
                new_len   = CW'(CAP_L - new_gl);
                done_next = 1'b1;
                rc_next   = '0;
                tl_next   = new_len[gbts_pkg::POS_W-1:0];
                st_next   = gbts_pkg::STAT_OK;
            end
            gbts_pkg::ST_READ:
            begin
                done_next = 1'b1;
                rc_next   = mem_rdata;
                tl_next   = len_x[gbts_pkg::POS_W-1:0];
                st_next   = gbts_pkg::STAT_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbts_pkg::ST_IDLE;
            gs_reg    <= '0;
            gl_reg    <= CAP_L;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rc_reg    <= '0;
            tl_reg    <= '0;
            st_reg    <= gbts_pkg::STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            gs_reg    <= gs_next;
            gl_reg    <= gl_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            rc_reg    <= rc_next;
            tl_reg    <= tl_next;
            st_reg    <= st_next;
        end
    end

    // operands of the action in progress
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        char_reg <= char_next;
        cnt_reg  <= cnt_next;
        tgt_reg  <= tgt_next;
        wa_reg   <= wa_next;
    end

    assign busy        = (state_reg != gbts_pkg::ST_IDLE);
    assign done        = done_reg;
    assign read_char   = rc_reg;
    assign text_length = tl_reg;
    assign status      = st_reg;

endmodule

`default_nettype wire

@@ rtl/gap_buffer_text_store_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// flow: a refused action answers from idle, a read passes the read state, an insert
//   or remove the walk and exec states; the walk is empty with the gap in place
// throughput: one action at a time; the gap walk moves one character per cycle
//   through the single write port of the character ram, start is taken once busy is low
// reset: empty text, gap over the whole store; ram contents are not cleared
// results are shown for one cycle on done and cannot be stalled
// ----------------------------------------------------------------------------
// gap_buffer_text_store_unit
// fixed-capacity gap buffer of 16-bit characters with insert, remove and read
// ----------------------------------------------------------------------------
module gap_buffer_text_store_unit #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [gbts_pkg::ACT_W-1:0]    action,
    input  wire logic [gbts_pkg::POS_W-1:0]    position,
    input  wire logic [gbts_pkg::CHAR_W-1:0]   character,
    input  wire logic [gbts_pkg::POS_W-1:0]    count,
    output logic                               done,
    output logic      [gbts_pkg::CHAR_W-1:0]   read_char,
    output logic      [gbts_pkg::POS_W-1:0]    text_length,
    output logic      [gbts_pkg::STAT_W-1:0]   status
);

    localparam int AW = $clog2(CAPACITY);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [gbts_pkg::CHAR_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [gbts_pkg::CHAR_W-1:0] mem_rdata;

    gbts_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .position    (position),
        .character   (character),
        .count       (count),
        .busy        (busy),
        .done        (done),
        .read_char   (read_char),
        .text_length (text_length),
        .status      (status),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    gbts_ram #(
        .WIDTH (gbts_pkg::CHAR_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    // every result comes from an accepted transfer or an action in progress
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a transfer");

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // refused actions never carry a character
    a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != gbts_pkg::STAT_OK) |-> (read_char == '0))
        else $error("character on refused action");

    // length only moves together with a result
    a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> (done || $stable(text_length)))
        else $error("length changed without a result");
`endif

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gap buffer text store: commands are driven
// through the start/busy handshake, a mirror of the text and its gap predicts
// each reply, and every done strobe is compared field by field
// ----------------------------------------------------------------------------
module tb;
    import gbts_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int PERIOD       = 10;
    localparam int RANDOM_ITEMS = 1350;
    localparam int MAX_TEXT     = 1024;
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [POS_W-1:0]  text_length;
        logic [STAT_W-1:0] status;
    } text_reply_t;

    // mirror of the store contents and gap, with the replies still owed by the block
    class gap_text_mirror;
        bit [CHAR_W-1:0] chars [CAP];
        int              gap_start;
        int              gap_len;
        text_reply_t     owed_replies [$];
        int              errors;

        function new();
            gap_start = 0;
            gap_len   = CAP;
            errors    = 0;
        endfunction

        function int text_len();
            return CAP - gap_len;
        endfunction

        function bit [CHAR_W-1:0] peek(int idx);
            return (idx < CAP) ? chars[idx] : '0;
        endfunction

        function void walk_gap(int target);
            while (gap_start < target)
            begin
                chars[gap_start] = peek(gap_start + gap_len);
                gap_start++;
            end
            while (gap_start > target)
            begin
                chars[gap_start + gap_len - 1] = peek(gap_start - 1);
                gap_start--;
            end
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic [CHAR_W-1:0] ch, logic [POS_W-1:0] cnt);
            text_reply_t r;
            int          len;
            int          p;
            int          c;
            r   = '0;
            len = text_len();
            p   = pos;
            c   = cnt;
            case (act)
                ACT_INSERT:
                begin
                    if (p > len)
                        r.status = STAT_RANGE;
                    else if (gap_len == 0)
                        r.status = STAT_FULL;
                    else
                    begin
                        walk_gap(p);
                        chars[p] = ch;
                        gap_start++;
                        gap_len--;
                    end
                end
                ACT_REMOVE:
                begin
                    if (p + c > len)
                        r.status = STAT_RANGE;
                    else
                    begin
                        walk_gap(p + c);
                        gap_start -= c;
                        gap_len   += c;
                    end
                end
                ACT_READ:
                begin
                    if (p >= len)
                        r.status = STAT_RANGE;
                    else if (p < gap_start)
                        r.read_char = chars[p];
                    else
                        r.read_char = peek(p + gap_len);
                end
                default:
                    r.status = STAT_RANGE;
            endcase
            r.text_length = POS_W'(CAP - gap_len);
            owed_replies.push_back(r);
        endfunction

        function void check_reply(logic [CHAR_W-1:0] rd, logic [POS_W-1:0] len,
                                  logic [STAT_W-1:0] st);
            text_reply_t exp;
            if (owed_replies.size() == 0)
            begin
                $display("%0t reply with no command outstanding: read_char %h length %0d status %0d",
                         $time, rd, len, st);
                errors++;
                return;
            end
            exp = owed_replies.pop_front();
            if (rd !== exp.read_char)
            begin
                $display("%0t read_char expected %h actual %h", $time, exp.read_char, rd);
                errors++;
            end
            if (len !== exp.text_length)
            begin
                $display("%0t text_length expected %0d actual %0d", $time, exp.text_length, len);
                errors++;
            end
            if (st !== exp.status)
            begin
                $display("%0t status expected %0d actual %0d", $time, exp.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [ACT_W-1:0]    action      = ACT_READ;
    logic [POS_W-1:0]    position    = '0;
    logic [CHAR_W-1:0]   character   = '0;
    logic [POS_W-1:0]    count       = '0;
    logic                busy;
    logic                done;
    logic [CHAR_W-1:0]   read_char;
    logic [POS_W-1:0]    text_length;
    logic [STAT_W-1:0]   status;

    gap_text_mirror mirror = new();
    int             cycles = 0;

    gap_buffer_text_store_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .position    (position),
        .character   (character),
        .count       (count),
        .done        (done),
        .read_char   (read_char),
        .text_length (text_length),
        .status      (status)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_reply(read_char, text_length, status);
    end

    task automatic pause(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off until every owed reply has come back
    task automatic drain();
        start <= 1'b0;
        while (mirror.owed_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic transfer(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                            logic [CHAR_W-1:0] ch, logic [POS_W-1:0] cnt, bit quiet);
        start     <= 1'b1;
        action    <= act;
        position  <= pos;
        character <= ch;
        count     <= cnt;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        mirror.note_command(act, pos, ch, cnt);
        if (!quiet && $urandom_range(0, 99) < 25)
            pause($urandom_range(1, 6));
    endtask

    // mostly short gap moves, now and then a jump anywhere in the text
    function automatic int near_gap(int gs, int len);
        int p;
        if ($urandom_range(0, 99) < 70)
            p = gs + int'($urandom_range(0, 32)) - 16;
        else
            p = $urandom_range(0, len);
        if (p < 0)
            p = 0;
        if (p > len)
            p = len;
        return p;
    endfunction

    task automatic random_command(bit quiet);
        logic [ACT_W-1:0]  act;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  cnt;
        int                len;
        int                pick;
        int                p;
        int                c;
        int                room;
        len  = mirror.text_len();
        ch   = CHAR_W'($urandom);
        cnt  = POS_W'($urandom);
        pos  = POS_W'($urandom);
        act  = ACT_READ;
        pick = $urandom_range(0, 99);
        if (pick < 45 && len >= MAX_TEXT)
            pick = 50;
        if (pick >= 55 && pick < 85 && len == 0)
            pick = 0;
        if (pick < 45)
        begin
            act = ACT_INSERT;
            pos = POS_W'(near_gap(mirror.gap_start, len));
        end
        else if (pick < 55)
        begin
            act  = ACT_REMOVE;
            p    = near_gap(mirror.gap_start, len);
            room = len - p;
            c    = $urandom_range(0, (room < 8) ? room : 8);
            if ($urandom_range(0, 9) == 0)
                c = $urandom_range(0, room);
            pos = POS_W'(p);
            cnt = POS_W'(c);
        end
        else if (pick < 85)
        begin
            act = ACT_READ;
            pos = POS_W'($urandom_range(0, len - 1));
        end
        else
        begin
            // refused commands, reaching the top bits of position and count
            case ($urandom_range(0, 3))
                0: act = ACT_UNUSED;
                1:
                begin
                    act = ACT_INSERT;
                    pos = POS_W'($urandom_range(len + 1, POS_MAX));
                end
                2:
                begin
                    act = ACT_REMOVE;
                    p   = $urandom_range(0, len);
                    pos = POS_W'(p);
                    cnt = POS_W'($urandom_range(len - p + 1, POS_MAX));
                end
                default:
                begin
                    act = ACT_READ;
                    pos = POS_W'($urandom_range(len, POS_MAX));
                end
            endcase
        end
        transfer(act, pos, ch, cnt, quiet);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, extremes of the fields, refusals
        transfer(ACT_READ,   13'd0,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_REMOVE, 13'd0,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd1,    16'h1234, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd0,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd1,    16'hFFFF, 13'h1FFF, 1'b0);
        transfer(ACT_INSERT, 13'd0,    16'hA5A5, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd3,    16'h5A5A, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd5,    16'h7777, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd0,    16'hFFFF, 13'h1FFF, 1'b0);
        transfer(ACT_READ,   13'd1,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd2,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd3,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd4,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_READ,   13'h1FFF, 16'h0000, 13'd0,    1'b0);
        transfer(ACT_UNUSED, 13'h1FFF, 16'hFFFF, 13'h1FFF, 1'b0);
        transfer(ACT_REMOVE, 13'd1,    16'h0000, 13'd2,    1'b0);
        transfer(ACT_REMOVE, 13'd0,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_REMOVE, 13'h1FFF, 16'h0000, 13'h1FFF, 1'b0);
        transfer(ACT_REMOVE, 13'd0,    16'h0000, 13'd4096, 1'b0);
        transfer(ACT_INSERT, 13'h1FFF, 16'hFFFF, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd0,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd1,    16'h0000, 13'd0,    1'b0);
        transfer(ACT_REMOVE, 13'd0,    16'h0000, 13'd2,    1'b0);
        transfer(ACT_READ,   13'd0,    16'h0000, 13'd0,    1'b0);
        drain();

        // fill by appending, then knock on a full store
        while (mirror.text_len() < CAP)
            transfer(ACT_INSERT, POS_W'(mirror.text_len()), CHAR_W'($urandom),
                     POS_W'($urandom), 1'b0);
        transfer(ACT_INSERT, 13'd0,    16'hBEEF, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd4096, 16'hBEEF, 13'd0,    1'b0);
        transfer(ACT_INSERT, 13'd4097, 16'hBEEF, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd4095, 16'h0000, 13'd0,    1'b0);
        transfer(ACT_READ,   13'd4096, 16'h0000, 13'd0,    1'b0);
        transfer(ACT_REMOVE, 13'd100,  16'h0000, 13'd3996, 1'b0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            random_command(i >= 400 && i < 700);
            if (i % 300 == 299)
                drain();
        end

        drain();
        repeat (16) @(posedge clk);
        if (mirror.errors == 0 && mirror.owed_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
